// ----- rtl/psp_pkg.sv -----
// shared types, sizes and codes for the per-unit sorted priority insert block
// no dependencies
`default_nettype none

package psp_pkg;

    localparam int NUM_SORTED_LISTS = 32;
    localparam int SORTED_SLOTS     = 5;
    localparam int NUM_PAIR_LISTS   = 32;
    localparam int PAIR_SLOTS       = 2;

    localparam int SORTED_IDX_W = $clog2(NUM_SORTED_LISTS);
    localparam int PAIR_IDX_W   = $clog2(NUM_PAIR_LISTS);
    localparam int SLOT_W       = $clog2(SORTED_SLOTS);
    localparam int POS_W        = 3;

    localparam logic [7:0] SORTED_BIAS = 8'h6c;
    localparam logic [7:0] PAIR_BIAS   = 8'h8a;

    // list_mode codes, off and spare both ignore requests
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_PAIR   = 2'd1;
    localparam logic [1:0] MODE_SORTED = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // outcome codes
    localparam logic [1:0] OUT_STORED   = 2'd0;
    localparam logic [1:0] OUT_REJECTED = 2'd1;
    localparam logic [1:0] OUT_IGNORED  = 2'd2;
    localparam logic [1:0] OUT_RANGE    = 2'd3;

    // one list entry, same bit layout as the stored word
    typedef struct packed {
        logic [11:0] prim;
        logic [11:0] sec;
        logic [7:0]  tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef entry_t [SORTED_SLOTS-1:0] sorted_row_t;
    typedef entry_t [PAIR_SLOTS-1:0]   pair_row_t;

endpackage

`default_nettype wire

// ----- rtl/psp_row_ram.sv -----
// generic single-port-write, single-port-read row memory, registered read
// no dependencies
`default_nettype none

module psp_row_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psp_sort_merge.sv -----
// insert position search and shifted row for the sorted lists
// depends on psp_pkg
`default_nettype none

module psp_sort_merge (
    input  wire psp_pkg::sorted_row_t             row,
    input  wire psp_pkg::entry_t                  item,
    output logic                                  found,
    output logic [psp_pkg::SLOT_W-1:0]            pos,
    output psp_pkg::sorted_row_t                  new_row
);

    logic [psp_pkg::SORTED_SLOTS-1:0] beat;

    // item goes ahead of slot j: higher key, or equal key and lower tie breaker
    always_comb
    begin
        for (int j = 0; j < psp_pkg::SORTED_SLOTS; j++)
        begin
            beat[j] = (row[j].prim < item.prim) ||
                      ((row[j].prim == item.prim) && (row[j].sec > item.sec));
        end
    end

    // first slot that the item beats
    always_comb
    begin
        pos = '0;
        for (int j = psp_pkg::SORTED_SLOTS - 1; j >= 0; j--)
        begin
            if (beat[j])
            begin
                pos = psp_pkg::SLOT_W'(j);
            end
        end
        found = |beat;
    end

    always_comb
    begin
        new_row[0] = (pos == '0) ? item : row[0];
        for (int j = 1; j < psp_pkg::SORTED_SLOTS; j++)
        begin
            if (psp_pkg::SLOT_W'(j) < pos)
            begin
                new_row[j] = row[j];
            end
            else if (psp_pkg::SLOT_W'(j) == pos)
            begin
                new_row[j] = item;
            end
            else
            begin
                new_row[j] = row[j-1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/per_unit_sorted_priority_insert.sv -----
// top level: request decode, read-modify-write sequencer, result register
// depends on psp_pkg, psp_row_ram, psp_sort_merge
`default_nettype none

// channel   direction  handshake            payload
// request   in         in_valid / in_stall  enabled unit_id entry_tag primary_key
//                                           secondary_key alt_slot
// result    out        out_valid/out_stall  outcome position
// config    in         cfg_wr_en            cfg_wr_data (list_mode)
//
// one request at a time: accept, row read, compare and merge, write-back with
// result load, in that order, for a request that touches a list; an ignored or
// out-of-range request skips the memory and goes straight to the result load
// the loop is the single read port of each row memory and the merge after it
// reset clears the per-row valid flops at once; an unwritten row reads as zero,
// so no clearing pass is needed
// a stalled result waits in the output register; the write-back and the next
// result load hold until that register is free, then new requests are taken

module per_unit_sorted_priority_insert (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        enabled,
    input  wire logic [7:0]  unit_id,
    input  wire logic [7:0]  entry_tag,
    input  wire logic [11:0] primary_key,
    input  wire logic [11:0] secondary_key,
    input  wire logic        alt_slot,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       outcome,
    output logic [2:0]       position
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SORTED,
        OP_PAIR
    } op_t;

    localparam int SROW_W = psp_pkg::SORTED_SLOTS * psp_pkg::ENTRY_W;
    localparam int PROW_W = psp_pkg::PAIR_SLOTS * psp_pkg::ENTRY_W;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [1:0] list_mode_reg;

    // request held for the sequencer
    psp_pkg::entry_t                   item_reg;
    logic                              slot_reg;
    logic [psp_pkg::SORTED_IDX_W-1:0]  sidx_reg;
    logic [psp_pkg::PAIR_IDX_W-1:0]    pidx_reg;

    // merge results waiting for write-back
    psp_pkg::sorted_row_t              srow_new_reg;
    psp_pkg::pair_row_t                prow_new_reg;
    logic                              s_wr_reg, s_wr_next;
    logic                              p_wr_reg, p_wr_next;
    logic [1:0]                        res_outcome_reg, res_outcome_next;
    logic [psp_pkg::POS_W-1:0]         res_pos_reg, res_pos_next;

    logic                              out_valid_reg;
    logic [1:0]                        outcome_reg;
    logic [psp_pkg::POS_W-1:0]         position_reg;

    // rows that have been written since reset
    logic [psp_pkg::NUM_SORTED_LISTS-1:0] s_vld_reg;
    logic [psp_pkg::NUM_PAIR_LISTS-1:0]   p_vld_reg;

    logic in_accept;
    logic out_free;
    logic commit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_FINISH) && out_free;

    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;
    assign position  = position_reg;

    // ---------------------------------------------------------------- decode
    logic [7:0] s_diff, p_diff;
    logic       s_in_range, p_in_range;

    assign s_diff = unit_id - psp_pkg::SORTED_BIAS;
    assign p_diff = unit_id - psp_pkg::PAIR_BIAS;

    // the bias subtraction wraps below the bias, so check both ends
    assign s_in_range = (unit_id >= psp_pkg::SORTED_BIAS) &&
                        (int'(s_diff) < psp_pkg::NUM_SORTED_LISTS);
    assign p_in_range = (unit_id >= psp_pkg::PAIR_BIAS) &&
                        (int'(p_diff) < psp_pkg::NUM_PAIR_LISTS) &&
                        (int'(alt_slot) < psp_pkg::PAIR_SLOTS);

    // ---------------------------------------------------------------- memories
    logic [SROW_W-1:0] srow_rd;
    logic [PROW_W-1:0] prow_rd;

    psp_row_ram #(
        .WIDTH (SROW_W),
        .DEPTH (psp_pkg::NUM_SORTED_LISTS)
    ) u_sorted_ram (
        .clk   (clk),
        .we    (commit && s_wr_reg),
        .waddr (sidx_reg),
        .wdata (srow_new_reg),
        .re    ((state_reg == ST_READ) && (op_reg == OP_SORTED)),
        .raddr (sidx_reg),
        .rdata (srow_rd)
    );

    psp_row_ram #(
        .WIDTH (PROW_W),
        .DEPTH (psp_pkg::NUM_PAIR_LISTS)
    ) u_pair_ram (
        .clk   (clk),
        .we    (commit && p_wr_reg),
        .waddr (pidx_reg),
        .wdata (prow_new_reg),
        .re    ((state_reg == ST_READ) && (op_reg == OP_PAIR)),
        .raddr (pidx_reg),
        .rdata (prow_rd)
    );

    // ---------------------------------------------------------------- merge
    // a row not yet written reads as all-zero entries
    psp_pkg::sorted_row_t srow_cur, srow_merged;
    psp_pkg::pair_row_t   prow_cur, prow_merged;
    psp_pkg::entry_t      pair_old;
    logic                 s_found;
    logic [psp_pkg::SLOT_W-1:0] s_pos;

    assign srow_cur = s_vld_reg[sidx_reg] ? psp_pkg::sorted_row_t'(srow_rd) : '0;
    assign prow_cur = p_vld_reg[pidx_reg] ? psp_pkg::pair_row_t'(prow_rd) : '0;

    psp_sort_merge u_merge (
        .row     (srow_cur),
        .item    (item_reg),
        .found   (s_found),
        .pos     (s_pos),
        .new_row (srow_merged)
    );

    assign pair_old = prow_cur[slot_reg];

    always_comb
    begin
        prow_merged           = prow_cur;
        prow_merged[slot_reg] = item_reg;
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        s_wr_next        = s_wr_reg;
        p_wr_next        = p_wr_reg;
        res_outcome_next = res_outcome_reg;
        res_pos_next     = res_pos_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    s_wr_next        = 1'b0;
                    p_wr_next        = 1'b0;
                    res_pos_next     = '0;
                    res_outcome_next = psp_pkg::OUT_IGNORED;
                    op_next          = OP_NONE;
                    if (enabled && (list_mode_reg == psp_pkg::MODE_SORTED))
                    begin
                        if (s_in_range)
                        begin
                            op_next = OP_SORTED;
                        end
                        else
                        begin
                            res_outcome_next = psp_pkg::OUT_RANGE;
                        end
                    end
                    else if (enabled && (list_mode_reg == psp_pkg::MODE_PAIR))
                    begin
                        if (p_in_range)
                        begin
                            op_next = OP_PAIR;
                        end
                        else
                        begin
                            res_outcome_next = psp_pkg::OUT_RANGE;
                        end
                    end
                    // no list touched: straight to the result
                    state_next = (op_next == OP_NONE) ? ST_FINISH : ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_CALC;
            end

            ST_CALC:
            begin
                if (op_reg == OP_SORTED)
                begin
                    if (s_found)
                    begin
                        s_wr_next        = 1'b1;
                        res_outcome_next = psp_pkg::OUT_STORED;
                        res_pos_next     = psp_pkg::POS_W'(s_pos);
                    end
                    else
                    begin
                        res_outcome_next = psp_pkg::OUT_REJECTED;
                    end
                end
                else
                begin
                    // stored key greater than the new one keeps its place
                    if (pair_old.prim > item_reg.prim)
                    begin
                        res_outcome_next = psp_pkg::OUT_REJECTED;
                    end
                    else
                    begin
                        p_wr_next        = 1'b1;
                        res_outcome_next = psp_pkg::OUT_STORED;
                        res_pos_next     = psp_pkg::POS_W'(slot_reg);
                    end
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_NONE;
            s_wr_reg        <= 1'b0;
            p_wr_reg        <= 1'b0;
            list_mode_reg   <= psp_pkg::MODE_OFF;
            s_vld_reg       <= '0;
            p_vld_reg       <= '0;
            out_valid_reg   <= 1'b0;
            outcome_reg     <= psp_pkg::OUT_STORED;
            position_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            s_wr_reg  <= s_wr_next;
            p_wr_reg  <= p_wr_next;

            if (cfg_wr_en)
            begin
                list_mode_reg <= cfg_wr_data;
            end

            if (commit && s_wr_reg)
            begin
                s_vld_reg[sidx_reg] <= 1'b1;
            end
            if (commit && p_wr_reg)
            begin
                p_vld_reg[pidx_reg] <= 1'b1;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                outcome_reg   <= res_outcome_next;
                position_reg  <= res_pos_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_outcome_reg <= res_outcome_next;
        res_pos_reg     <= res_pos_next;

        if (in_accept)
        begin
            item_reg.prim <= primary_key;
            item_reg.sec  <= secondary_key;
            item_reg.tag  <= entry_tag;
            slot_reg      <= alt_slot;
            sidx_reg      <= s_diff[psp_pkg::SORTED_IDX_W-1:0];
            pidx_reg      <= p_diff[psp_pkg::PAIR_IDX_W-1:0];
        end

        if (state_reg == ST_CALC)
        begin
            srow_new_reg <= srow_merged;
            prow_new_reg <= prow_merged;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psp_checker.sv -----
// port-level checks for per_unit_sorted_priority_insert, bound to the top level
// depends on psp_pkg and per_unit_sorted_priority_insert
`default_nettype none

module psp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  outcome,
    input wire logic [2:0]  position
);

    // one request in flight: the block is busy in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous one still in flight");

    // a waiting result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(outcome) && $stable(position)))
        else $error("stalled result changed");

    // position is zero unless something was stored
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome != psp_pkg::OUT_STORED)) |-> (position == 3'd0))
        else $error("non-zero position on a result that stored nothing");

    // a stored position lies inside the sorted list
    a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome == psp_pkg::OUT_STORED)) |->
        (int'(position) < psp_pkg::SORTED_SLOTS))
        else $error("stored position beyond the last slot");

endmodule

bind per_unit_sorted_priority_insert psp_checker u_psp_checker (.*);

`default_nettype wire
